// ===== design/assert_macros.svh =====
// Assertion macros for the port-level checker of the pixel mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DMX_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DMX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/dmx_map_pkg.sv =====
// Shared constants, types and helpers of the DMX universe to pixel mapper.
package dmx_map_pkg;

   localparam int MAX_PIXELS     = 1024;
   localparam int UNIVERSE_SLOTS = 512;

   localparam int UNIVERSE_W  = 16;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 11;
   localparam int PIXEL_W     = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // pixels carried by one universe in each color mode
   localparam logic [7:0] RGB_PER_UNIVERSE  = 8'(UNIVERSE_SLOTS / 3);
   localparam logic [7:0] RGBW_PER_UNIVERSE = 8'(UNIVERSE_SLOTS / 4);

   localparam logic [COUNT_W-1:0] STRIP_LIMIT = COUNT_W'(MAX_PIXELS);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_UNIVERSE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_MODE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_COUNT   = 2'd2;

   localparam logic [UNIVERSE_W-1:0] BASE_UNIVERSE_RESET = 16'd1;

   // color modes
   localparam logic MODE_RGB  = 1'b0;
   localparam logic MODE_RGBW = 1'b1;

   // last byte position within a pixel
   localparam logic [1:0] RGB_LAST_PHASE  = 2'd2;
   localparam logic [1:0] RGBW_LAST_PHASE = 2'd3;

   // divide by three as multiply by 683 / 2048, exact for sums up to 765
   localparam logic [9:0] DIV3_MUL   = 10'd683;
   localparam int         DIV3_SHIFT = 11;

   typedef struct packed {
      logic [UNIVERSE_W-1:0] universe;
      logic [BYTE_W-1:0]     data_byte;
      logic                  start_of_packet;
   } req_item_type;

   // strip length with the pixel count saturated to the supported maximum
   function automatic logic [COUNT_W-1:0] strip_size(input logic [COUNT_W-1:0] count);
      strip_size = (count > STRIP_LIMIT) ? STRIP_LIMIT : count;
   endfunction

endpackage

// ===== design/dmx_universe_to_pixel_mapper.sv =====
// DMX universe to RGB/RGBW pixel mapper top level.
//
// Takes E1.31 DMX packet bytes one item at a time on the req_ channel, each tagged with its
// universe number; an item with start_of_packet set is the start code and opens a packet.
// The start code checks that the universe lies in the span the strip covers and places the
// packet at pixel (universe - base universe) * 170 in RGB mode or * 128 in RGBW mode.
// Following slot bytes group into pixels of three or four bytes; each complete pixel below
// the end of that universe's share of the strip comes out as one rsp_ item. In RGB mode
// white is the truncated average of red, green and blue. Bytes outside an open packet, a
// trailing partial pixel and pixels at or past the strip end produce nothing. A new start
// code discards any partial pixel. A write to any defined register closes the open packet;
// write the registers only while no item is in flight. The pixel count saturates at 1024.
// Rate: one item per clock cycle while req_stall is low. The accepting edge loads the input
// register; the pixel that the item completes loads the result register once that is free
// and shows on rsp_ from there. req_stall rises only while a finished pixel waits in the
// result register under rsp_stall and the item in the input register completes another pixel.
module dmx_universe_to_pixel_mapper
   import dmx_map_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input byte channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [UNIVERSE_W-1:0]  req_universe,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_start_of_packet,
   // pixel result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_pixel_index,
   output logic [BYTE_W-1:0]      rsp_red,
   output logic [BYTE_W-1:0]      rsp_green,
   output logic [BYTE_W-1:0]      rsp_blue,
   output logic [BYTE_W-1:0]      rsp_white,
   // register write port
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // configuration registers
   logic [UNIVERSE_W-1:0] base_universe_ff;
   logic                  color_mode_ff;
   logic [COUNT_W-1:0]    pixel_count_ff;

   // input register
   logic         stage_valid_ff, stage_valid_in;
   req_item_type stage_ff;

   // packet state
   logic               active_ff, active_in;
   logic [COUNT_W-1:0] next_pixel_ff, next_pixel_in;
   logic [COUNT_W-1:0] end_pixel_ff, end_pixel_in;
   logic [1:0]         byte_phase_ff, byte_phase_in;
   logic [BYTE_W-1:0]  held_ff [3];
   logic [BYTE_W-1:0]  held_in [3];

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_index_ff;
   logic [BYTE_W-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_white_ff;

   // datapath
   logic                  rgbw;
   logic [7:0]            per_universe;
   logic [COUNT_W-1:0]    size;
   logic [UNIVERSE_W-1:0] universe_offset;
   logic [23:0]           base_full;
   logic                  map_ok;
   logic [COUNT_W-1:0]    base_pixel;
   logic [COUNT_W:0]      base_plus;
   logic [COUNT_W-1:0]    end_pixel;
   logic [1:0]            last_phase;
   logic                  pixel_done;
   logic [COUNT_W-1:0]    next_pixel_inc;
   logic [9:0]            rgb_sum;
   logic [20:0]           avg_product;
   logic [BYTE_W-1:0]     pixel_blue, pixel_white;
   logic                  out_free, advance, req_accept, csr_hit;

   assign rgbw         = (color_mode_ff == MODE_RGBW);
   assign per_universe = rgbw ? RGBW_PER_UNIVERSE : RGB_PER_UNIVERSE;
   assign size         = strip_size(pixel_count_ff);

   // start code: place the packet on the strip
   assign universe_offset = stage_ff.universe - base_universe_ff;
   assign base_full       = 24'(universe_offset) * 24'(per_universe);
   // offset below ceil(size / per_universe) is the same as base below size
   assign map_ok     = (stage_ff.universe >= base_universe_ff) && (base_full < 24'(size));
   assign base_pixel = base_full[COUNT_W-1:0];
   assign base_plus  = (COUNT_W+1)'(base_pixel) + (COUNT_W+1)'(per_universe);
   assign end_pixel  = (base_plus > (COUNT_W+1)'(size)) ? size : base_plus[COUNT_W-1:0];

   // slot bytes: the last byte of a pixel completes it
   assign last_phase = rgbw ? RGBW_LAST_PHASE : RGB_LAST_PHASE;
   assign pixel_done = stage_valid_ff && !stage_ff.start_of_packet && active_ff
                       && (byte_phase_ff == last_phase);
   assign next_pixel_inc = next_pixel_ff + COUNT_W'(1);

   // RGB white: truncated average through the reciprocal of three
   assign rgb_sum     = 10'(held_ff[0]) + 10'(held_ff[1]) + 10'(stage_ff.data_byte);
   assign avg_product = 21'(rgb_sum) * 21'(DIV3_MUL);
   assign pixel_blue  = rgbw ? held_ff[2] : stage_ff.data_byte;
   assign pixel_white = rgbw ? stage_ff.data_byte : avg_product[DIV3_SHIFT +: BYTE_W];

   // handshake: items without a pixel pass even while the result register is held
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = stage_valid_ff && (!pixel_done || out_free);
   assign req_stall  = stage_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign csr_hit = csr_write_enable && ((csr_index == CSR_BASE_UNIVERSE)
                    || (csr_index == CSR_COLOR_MODE) || (csr_index == CSR_PIXEL_COUNT));

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      active_in     = active_ff;
      next_pixel_in = next_pixel_ff;
      end_pixel_in  = end_pixel_ff;
      byte_phase_in = byte_phase_ff;
      held_in       = held_ff;
      if (advance) begin
         if (stage_ff.start_of_packet) begin
            // open a new packet, drop any partial pixel
            active_in     = map_ok;
            byte_phase_in = 2'd0;
            if (map_ok) begin
               next_pixel_in = base_pixel;
               end_pixel_in  = end_pixel;
            end
         end else if (active_ff) begin
            if (pixel_done) begin
               byte_phase_in = 2'd0;
               next_pixel_in = next_pixel_inc;
               // close the packet at the end of its share of the strip
               if (next_pixel_inc >= end_pixel_ff) begin
                  active_in = 1'b0;
               end
            end else begin
               case (byte_phase_ff)
                  2'd0:    held_in[0] = stage_ff.data_byte;
                  2'd1:    held_in[1] = stage_ff.data_byte;
                  2'd2:    held_in[2] = stage_ff.data_byte;
                  default: ;
               endcase
               byte_phase_in = byte_phase_ff + 2'd1;
            end
         end
      end
      // any register write abandons the open packet
      if (csr_hit) begin
         active_in     = 1'b0;
         byte_phase_in = 2'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && pixel_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_universe_ff <= BASE_UNIVERSE_RESET;
         color_mode_ff    <= MODE_RGB;
         pixel_count_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE_UNIVERSE: base_universe_ff <= csr_write_data[UNIVERSE_W-1:0];
            CSR_COLOR_MODE:    color_mode_ff    <= csr_write_data[0];
            CSR_PIXEL_COUNT:   pixel_count_ff   <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         active_ff      <= 1'b0;
         next_pixel_ff  <= '0;
         end_pixel_ff   <= '0;
         byte_phase_ff  <= 2'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         active_ff      <= active_in;
         next_pixel_ff  <= next_pixel_in;
         end_pixel_ff   <= end_pixel_in;
         byte_phase_ff  <= byte_phase_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (req_accept) begin
         stage_ff.universe        <= req_universe;
         stage_ff.data_byte       <= req_data_byte;
         stage_ff.start_of_packet <= req_start_of_packet;
      end
      if (advance && pixel_done) begin
         rsp_index_ff <= next_pixel_ff[PIXEL_W-1:0];
         rsp_red_ff   <= held_ff[0];
         rsp_green_ff <= held_ff[1];
         rsp_blue_ff  <= pixel_blue;
         rsp_white_ff <= pixel_white;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_red         = rsp_red_ff;
   assign rsp_green       = rsp_green_ff;
   assign rsp_blue        = rsp_blue_ff;
   assign rsp_white       = rsp_white_ff;

endmodule

// ===== design/dmx_map_checker.sv =====
// Port-level assertion checker for the DMX universe to pixel mapper, with its bind.
`include "assert_macros.svh"

module dmx_map_checker
   import dmx_map_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [PIXEL_W-1:0]     rsp_pixel_index,
   input logic [BYTE_W-1:0]      rsp_red,
   input logic [BYTE_W-1:0]      rsp_green,
   input logic [BYTE_W-1:0]      rsp_blue,
   input logic [BYTE_W-1:0]      rsp_white,
   input logic                   csr_write_enable,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_write_data
);

   // shadow copies of the registers that bound the results
   logic               mode_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] size_limit;
   logic [9:0]         rgb_sum, white_x3;
   logic               rgb_item, white_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RGB;
         count_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COLOR_MODE:  mode_ff  <= csr_write_data[0];
            CSR_PIXEL_COUNT: count_ff <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign size_limit = strip_size(count_ff);
   assign rgb_sum    = 10'(rsp_red) + 10'(rsp_green) + 10'(rsp_blue);
   assign white_x3   = 10'(rsp_white) + 10'(rsp_white) + 10'(rsp_white);
   assign rgb_item   = rsp_valid && (mode_ff == MODE_RGB);
   assign white_ok   = (white_x3 <= rgb_sum) && (rgb_sum < white_x3 + 10'd3);

   // a held pixel stays until taken
   `DMX_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")

   // the input side stalls only behind a waiting pixel
   `DMX_ASSERT_RST(a_stall_cause, clock, reset, !rsp_valid |-> !req_stall, "input stalled with an empty result register")

   // every pixel lands on the strip
   `DMX_ASSERT_RST(a_index_range, clock, reset, rsp_valid |-> (COUNT_W'(rsp_pixel_index) < size_limit), "pixel index past strip end")

   // RGB white is the truncated average of the three colors
   `DMX_ASSERT_RST(a_white_avg, clock, reset, rgb_item |-> white_ok, "RGB white is not the average")

endmodule

bind dmx_universe_to_pixel_mapper dmx_map_checker u_dmx_map_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the DMX universe to pixel mapper: directed cases, then random packets.
module tb_top
   import dmx_map_pkg::*;
();

   localparam int CYCLE_LIMIT   = 600000;  // far beyond the slowest legal run
   localparam int SETTLE_CYCLES = 4;       // input and result registers plus margin
   localparam int RANDOM_BYTES  = 840;     // bytes wanted from the random part
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [PIXEL_W-1:0] index;
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
      logic [BYTE_W-1:0]  white;
   } pixel_value_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_type;

   logic                   clock;
   logic                   reset               = 1'b1;
   logic                   req_valid           = 1'b0;
   logic                   req_stall;
   logic [UNIVERSE_W-1:0]  req_universe        = '0;
   logic [BYTE_W-1:0]      req_data_byte       = '0;
   logic                   req_start_of_packet = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall           = 1'b0;
   logic [PIXEL_W-1:0]     rsp_pixel_index;
   logic [BYTE_W-1:0]      rsp_red;
   logic [BYTE_W-1:0]      rsp_green;
   logic [BYTE_W-1:0]      rsp_blue;
   logic [BYTE_W-1:0]      rsp_white;
   logic                   csr_write_enable    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index           = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data      = '0;

   dmx_universe_to_pixel_mapper uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_universe        (req_universe),
      .req_data_byte       (req_data_byte),
      .req_start_of_packet (req_start_of_packet),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pixel_index     (rsp_pixel_index),
      .rsp_red             (rsp_red),
      .rsp_green           (rsp_green),
      .rsp_blue            (rsp_blue),
      .rsp_white           (rsp_white),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Mapper model: register copies and packet state, updated as items
   // are accepted and registers are written.
   // ------------------------------------------------------------------
   logic [UNIVERSE_W-1:0] cfg_base_universe;
   logic                  cfg_color_mode;
   logic [COUNT_W-1:0]    cfg_pixel_count;

   logic                  map_active;
   logic [COUNT_W-1:0]    map_next_pixel;
   logic [COUNT_W-1:0]    map_end_pixel;
   logic [1:0]            map_phase;
   logic [BYTE_W-1:0]     map_held [0:2];

   pixel_value_type pending_pixels [$];

   int unsigned bytes_sent;
   int unsigned mapped_bytes;
   int unsigned pixels_checked;
   int unsigned registers_written;
   int unsigned mismatches;
   int unsigned cycle_count;
   int          burst_left;

   // Mirror the register write; any known register closes the open packet.
   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_BASE_UNIVERSE: cfg_base_universe = data;
         CSR_COLOR_MODE:    cfg_color_mode = data[0];
         CSR_PIXEL_COUNT:   cfg_pixel_count = data[COUNT_W-1:0];
         default:           return;
      endcase
      map_active = 1'b0;
      map_phase  = '0;
   endfunction

   // Advance the packet state by one byte; return 1 when a pixel completes.
   function automatic logic map_byte(input logic [UNIVERSE_W-1:0] uni,
                                     input logic [BYTE_W-1:0] data,
                                     input logic sop,
                                     output pixel_value_type px);
      int unsigned bpp, per_uni, size, span, offset, base, stop, sum;
      bpp      = (cfg_color_mode == MODE_RGBW) ? 4 : 3;
      per_uni  = UNIVERSE_SLOTS / bpp;
      px       = '0;
      map_byte = 1'b0;
      if (sop) begin
         size       = (cfg_pixel_count > MAX_PIXELS) ? MAX_PIXELS : cfg_pixel_count;
         span       = (size + per_uni - 1) / per_uni;
         map_active = 1'b0;
         map_phase  = '0;
         offset     = int'(uni) - int'(cfg_base_universe);
         if (uni >= cfg_base_universe && offset < span) begin
            base = offset * per_uni;
            stop = base + per_uni;
            if (stop > size) stop = size;
            map_next_pixel = base[COUNT_W-1:0];
            map_end_pixel  = stop[COUNT_W-1:0];
            map_active     = base < stop;
         end
      end else if (map_active) begin
         if (map_phase + 1 < bpp) begin
            map_held[map_phase] = data;
            map_phase = map_phase + 2'd1;
         end else begin
            px.index = map_next_pixel[PIXEL_W-1:0];
            px.red   = map_held[0];
            px.green = map_held[1];
            if (bpp == 4) begin
               px.blue  = map_held[2];
               px.white = data;
            end else begin
               px.blue  = data;
               sum      = map_held[0] + map_held[1] + data;
               px.white = 8'(sum / 3);
            end
            map_phase      = '0;
            map_next_pixel = map_next_pixel + 11'd1;
            if (map_next_pixel >= map_end_pixel) map_active = 1'b0;
            map_byte = 1'b1;
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Watch the input channel: every accepted item goes through the model.
   always @(posedge clock) begin : watch_bytes
      pixel_value_type px;
      logic was_active;
      if (!reset && req_valid && !req_stall) begin
         was_active = map_active;
         if (map_byte(req_universe, req_data_byte, req_start_of_packet, px))
            pending_pixels.push_back(px);
         // count only bytes that open a mapped packet or land inside one
         if (req_start_of_packet ? map_active : was_active) mapped_bytes++;
         bytes_sent++;
      end
   end

   // Compare every accepted pixel with the oldest one the model produced.
   always @(posedge clock) begin : check_pixels
      pixel_value_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel at index %0d", rsp_pixel_index);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_index", 16'(want.index), 16'(rsp_pixel_index));
            check_field("red", 16'(want.red), 16'(rsp_red));
            check_field("green", 16'(want.green), 16'(rsp_green));
            check_field("blue", 16'(want.blue), 16'(rsp_blue));
            check_field("white", 16'(want.white), 16'(rsp_white));
            pixels_checked++;
         end
      end
   end

   // Receiver back-pressure: switch between no stall, one-in-three random stalls and
   // long stall runs so that stalls land on every phase of the pipeline.
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_left = $urandom_range(30, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         default:      rsp_stall <= ($urandom_range(0, 7) == 0) ? ~rsp_stall : rsp_stall;
      endcase
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Send one item. Work in bursts: at the end of a burst drop valid for a
   // random gap. Valid stays high after acceptance so back-to-back items
   // need only one assignment per step; wait_idle drops it.
   task automatic send_byte(input logic [UNIVERSE_W-1:0] uni, input logic [BYTE_W-1:0] data,
                            input logic sop);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid           <= 1'b1;
      req_universe        <= uni;
      req_data_byte       <= data;
      req_start_of_packet <= sop;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid, wait for every expected pixel, then let the pipe drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; call only while the block is idle.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      apply_reg(idx, data);
      registers_written++;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Start code plus len slot bytes; half the slot bytes carry a stray tag.
   task automatic send_packet(input logic [UNIVERSE_W-1:0] uni, input int unsigned len);
      send_byte(uni, 8'($urandom), 1'b1);
      repeat (len)
         send_byte($urandom_range(0, 1) ? uni : 16'($urandom), 8'($urandom), 1'b0);
   endtask

   task automatic send_noise(input int unsigned count);
      repeat (count)
         send_byte(16'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Out of reset the strip is empty, so nothing maps; then size the strip
   // with junk in the upper data bits and keep the reset first universe.
   task automatic test_reset_defaults();
      send_byte(16'd1, 8'h00, 1'b1);
      send_byte(16'd1, 8'h10, 1'b0);
      send_byte(16'd1, 8'h20, 1'b0);
      send_byte(16'd1, 8'h30, 1'b0);
      wait_idle();
      write_reg(CSR_PIXEL_COUNT, 16'hF954);   // 340 pixels, two universes
   endtask

   // RGB grouping, white average extremes, stray tags, universes out of
   // span, a restart inside a packet and a trailing partial pixel.
   task automatic test_rgb_packets();
      send_byte(16'd1, 8'hA5, 1'b1);
      send_byte(16'd1, 8'h00, 1'b0);
      send_byte(16'd1, 8'h00, 1'b0);
      send_byte(16'd1, 8'h00, 1'b0);
      send_byte(16'hFFFF, 8'hFF, 1'b0);
      send_byte(16'hFFFF, 8'hFF, 1'b0);
      send_byte(16'hFFFF, 8'hFE, 1'b0);
      send_byte(16'd0, 8'h00, 1'b1);          // below the span
      send_byte(16'd0, 8'h11, 1'b0);
      send_byte(16'd2, 8'hFF, 1'b1);
      send_byte(16'd2, 8'h12, 1'b0);
      send_byte(16'd2, 8'h00, 1'b1);          // restart: drop the partial pixel
      send_byte(16'd2, 8'hFF, 1'b0);
      send_byte(16'd2, 8'hFF, 1'b0);
      send_byte(16'd2, 8'hFF, 1'b0);
      send_byte(16'd2, 8'h01, 1'b0);
      send_byte(16'd2, 8'h02, 1'b0);
      send_byte(16'd3, 8'h00, 1'b1);          // above the span
      send_byte(16'd3, 8'h33, 1'b0);
      wait_idle();
   endtask

   // RGBW at the top universe with a one-pixel strip: the second pixel falls
   // past the strip end.
   task automatic test_rgbw_strip_end();
      write_reg(CSR_BASE_UNIVERSE, 16'hFFFF);
      write_reg(CSR_COLOR_MODE, {15'h7FFF, MODE_RGBW});
      write_reg(CSR_PIXEL_COUNT, 16'd1);
      send_byte(16'hFFFF, 8'h00, 1'b1);
      send_byte(16'hFFFF, 8'h01, 1'b0);
      send_byte(16'hFFFF, 8'h02, 1'b0);
      send_byte(16'hFFFF, 8'h03, 1'b0);
      send_byte(16'hFFFF, 8'h04, 1'b0);
      repeat (4) send_byte(16'hFFFF, 8'($urandom), 1'b0);
      send_byte(16'hFFFE, 8'h00, 1'b1);
      wait_idle();
   endtask

   // Pixel count above the maximum saturates: the last universe holds only
   // pixels 1020..1023, and the universe after it is out of span.
   task automatic test_count_saturation();
      write_reg(CSR_BASE_UNIVERSE, 16'd0);
      write_reg(CSR_COLOR_MODE, {15'd0, MODE_RGB});
      write_reg(CSR_PIXEL_COUNT, 16'hFFFF);
      send_byte(16'd6, 8'h00, 1'b1);
      repeat (15) send_byte(16'd6, 8'($urandom), 1'b0);
      send_byte(16'd7, 8'h00, 1'b1);
      send_byte(16'd7, 8'h77, 1'b0);
      wait_idle();
   endtask

   // A write to the unused index leaves the packet open; a real write closes it.
   task automatic test_register_write_closes();
      send_byte(16'd0, 8'h00, 1'b1);
      repeat (3) send_byte(16'd0, 8'($urandom), 1'b0);
      wait_idle();
      write_reg(CSR_UNUSED, 16'hFFFF);
      repeat (3) send_byte(16'd0, 8'($urandom), 1'b0);
      wait_idle();
      write_reg(CSR_COLOR_MODE, {15'd0, MODE_RGB});
      repeat (3) send_byte(16'd0, 8'($urandom), 1'b0);
      wait_idle();
   endtask

   // Random phases: set all registers, then mostly well-formed packets into
   // the span with random content, plus off-span packets and loose noise.
   task automatic test_random_traffic();
      int unsigned start_sent, phase, pick, per_uni, size, span, len;
      logic [UNIVERSE_W-1:0] first;
      logic                  mode;
      logic [COUNT_W-1:0]    count;
      start_sent = bytes_sent;
      phase = 0;
      while (bytes_sent - start_sent < RANDOM_BYTES && phase < 60) begin
         case (phase)
            0: begin first = 16'd0;     mode = MODE_RGB;  count = 11'd2047; end
            1: begin first = 16'hFFFF;  mode = MODE_RGBW; count = 11'd1024; end
            2: begin first = 16'($urandom); mode = MODE_RGBW; count = 11'd0; end
            3: begin first = 16'hFFFA;  mode = MODE_RGB;  count = 11'd1024; end
            default: begin
               pick  = $urandom_range(0, 3);
               first = (pick == 0) ? 16'($urandom) :
                       (pick == 1) ? 16'($urandom_range(65528, 65535)) :
                                     16'($urandom_range(0, 8));
               mode  = 1'($urandom_range(0, 1));
               count = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(1020, 2047))
                                                   : 11'($urandom_range(0, 400));
            end
         endcase
         write_reg(CSR_BASE_UNIVERSE, first);
         write_reg(CSR_COLOR_MODE, {15'($urandom), mode});
         write_reg(CSR_PIXEL_COUNT, {5'($urandom), count});
         if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, 16'($urandom));
         per_uni = UNIVERSE_SLOTS / ((mode == MODE_RGBW) ? 4 : 3);
         size    = (count > MAX_PIXELS) ? MAX_PIXELS : count;
         span    = (size + per_uni - 1) / per_uni;
         repeat ($urandom_range(2, 5)) begin
            pick = $urandom_range(0, 99);
            // mostly short packets, now and then a whole universe
            len  = ($urandom_range(0, 39) == 0) ? $urandom_range(480, 520)
                                                : $urandom_range(0, 45);
            if (pick < 75 && span > 0)
               send_packet(16'(first + $urandom_range(0, span - 1)), len);
            else if (pick < 90)
               send_packet(pick[0] ? 16'(first + span) : 16'($urandom), len);
            else
               send_noise($urandom_range(1, 12));
         end
         wait_idle();
         phase++;
      end
   endtask

   initial begin
      bytes_sent         = 0;
      mapped_bytes       = 0;
      pixels_checked     = 0;
      registers_written  = 0;
      mismatches         = 0;
      cycle_count        = 0;
      burst_left         = 0;
      cfg_base_universe  = BASE_UNIVERSE_RESET;
      cfg_color_mode     = MODE_RGB;
      cfg_pixel_count    = '0;
      map_active         = 1'b0;
      map_next_pixel     = '0;
      map_end_pixel      = '0;
      map_phase          = '0;
      map_held           = '{default: '0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_rgb_packets();
      test_rgbw_strip_end();
      test_count_saturation();
      test_register_write_closes();
      test_random_traffic();
      wait_idle();

      $display("summary: %0d bytes sent, %0d inside mapped packets, %0d pixels compared",
               bytes_sent, mapped_bytes, pixels_checked);
      $display("summary: %0d register writes across RGB/RGBW, strip sizes 0 to 2047",
               registers_written);
      if (mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
